>>> rtl/core/orlcc_pkg.sv
`default_nettype none

package orlcc_pkg;

   localparam int RULE_REGS  = 4;
   localparam int RULE_IDX_W = $clog2(RULE_REGS);
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RULE_COUNT    = 3'd0,
      CSR_RULE_ZERO     = 3'd1,
      CSR_RULE_ONE      = 3'd2,
      CSR_RULE_TWO      = 3'd3,
      CSR_RULE_THREE    = 3'd4,
      CSR_POSITIVE_LABEL = 3'd5
   } csr_index_type;

   typedef logic [RULE_IDX_W-1:0] rule_idx_type;

endpackage

`default_nettype wire

>>> rtl/core/ordered_rule_list_consistency_check.sv
// Path: an accepted item goes to the input register, then to the result register.
// Throughput: one item per cycle; req_ready drops only while a stalled result blocks a held item.
// Rule match is a parallel mask compare with a priority pick in the input-to-result path.
// Reset (synchronous, active high) clears the configuration registers, pipeline valids and set state.
// Set state also restarts after the item marked last is processed.
`default_nettype none

module ordered_rule_list_consistency_check #(
   parameter int MAX_RULES = 4,
   parameter int FEATURES  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [orlcc_pkg::MASK_W-1:0]       req_point_bits,
   input  wire logic                               req_point_class,
   input  wire logic                               req_last_point,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_still_separable,
   output logic                                    rsp_set_done,
   input  wire logic                               csr_wr_en,
   input  wire logic [orlcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [orlcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int EFF_MAX = (MAX_RULES < orlcc_pkg::RULE_REGS) ? MAX_RULES
                                                                : orlcc_pkg::RULE_REGS;
   localparam logic [orlcc_pkg::COUNT_W-1:0] EFF_MAX_C = orlcc_pkg::COUNT_W'(EFF_MAX);
   localparam logic [orlcc_pkg::MASK_W-1:0] FEAT_MASK =
      orlcc_pkg::MASK_W'((33'd1 << FEATURES) - 33'd1);

   // configuration
   logic [orlcc_pkg::COUNT_W-1:0]    rule_count_ff;
   logic [orlcc_pkg::CSR_DATA_W-1:0] rule_masks_ff [orlcc_pkg::RULE_REGS];
   logic                             positive_label_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff     <= '0;
         positive_label_ff <= 1'b0;
         for (int i = 0; i < orlcc_pkg::RULE_REGS; i++) begin
            rule_masks_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (orlcc_pkg::csr_index_type'(csr_index))
            orlcc_pkg::CSR_RULE_COUNT:     rule_count_ff <= csr_wdata[orlcc_pkg::COUNT_W-1:0];
            orlcc_pkg::CSR_RULE_ZERO:      rule_masks_ff[0] <= csr_wdata;
            orlcc_pkg::CSR_RULE_ONE:       rule_masks_ff[1] <= csr_wdata;
            orlcc_pkg::CSR_RULE_TWO:       rule_masks_ff[2] <= csr_wdata;
            orlcc_pkg::CSR_RULE_THREE:     rule_masks_ff[3] <= csr_wdata;
            orlcc_pkg::CSR_POSITIVE_LABEL: positive_label_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic                          s1_valid_ff;
   logic [orlcc_pkg::MASK_W-1:0]  s1_bits_ff;
   logic                          s1_class_ff;
   logic                          s1_last_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_sep_ff;
   logic                          rsp_done_ff;
   logic                          advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_bits_ff  <= req_point_bits;
         s1_class_ff <= req_point_class;
         s1_last_ff  <= req_last_point;
      end
   end

   // rule match and priority pick
   logic [orlcc_pkg::COUNT_W-1:0]  eff_count;
   logic [orlcc_pkg::MASK_W-1:0]   bits;
   logic [orlcc_pkg::RULE_REGS-1:0] covers;
   logic                           fired;
   orlcc_pkg::rule_idx_type        fired_idx;

   always_comb begin
      logic [orlcc_pkg::MASK_W-1:0] ones;
      logic [orlcc_pkg::MASK_W-1:0] zeros;
      eff_count = (rule_count_ff > EFF_MAX_C) ? EFF_MAX_C : rule_count_ff;
      bits      = s1_bits_ff & FEAT_MASK;
      for (int i = 0; i < orlcc_pkg::RULE_REGS; i++) begin
         ones      = rule_masks_ff[i][2*orlcc_pkg::MASK_W-1:orlcc_pkg::MASK_W] & FEAT_MASK;
         zeros     = rule_masks_ff[i][orlcc_pkg::MASK_W-1:0] & FEAT_MASK;
         covers[i] = (orlcc_pkg::COUNT_W'(i) < eff_count)
                     && ((bits & ones) == ones) && ((bits & zeros) == '0);
      end
      fired     = 1'b0;
      fired_idx = '0;
      for (int i = orlcc_pkg::RULE_REGS - 1; i >= 0; i--) begin
         if (covers[i]) begin
            fired     = 1'b1;
            fired_idx = orlcc_pkg::rule_idx_type'(i);
         end
      end
   end

   // set state
   logic                    pos_seen_ff, pos_seen_in;
   logic                    neg_seen_ff, neg_seen_in;
   orlcc_pkg::rule_idx_type hp_ff, hp_in;
   orlcc_pkg::rule_idx_type ln_ff, ln_in;
   logic                    failed_ff, failed_in;
   logic                    positive;
   logic                    fail_now;

   always_comb begin
      positive    = (s1_class_ff == positive_label_ff);
      pos_seen_in = pos_seen_ff;
      neg_seen_in = neg_seen_ff;
      hp_in       = hp_ff;
      ln_in       = ln_ff;
      fail_now    = failed_ff;
      if (!failed_ff) begin
         if (fired) begin
            if (positive) begin
               if (!pos_seen_ff || (fired_idx > hp_ff)) begin
                  pos_seen_in = 1'b1;
                  hp_in       = fired_idx;
                  if (neg_seen_ff && (fired_idx >= ln_ff)) begin
                     fail_now = 1'b1;
                  end
               end
            end else if (!neg_seen_ff || (fired_idx < ln_ff)) begin
               neg_seen_in = 1'b1;
               ln_in       = fired_idx;
               if (pos_seen_ff && (hp_ff >= fired_idx)) begin
                  fail_now = 1'b1;
               end
            end
         end else if (positive) begin
            fail_now = 1'b1;
         end
      end
      failed_in = fail_now;
      if (s1_last_ff) begin
         pos_seen_in = 1'b0;
         neg_seen_in = 1'b0;
         failed_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_seen_ff <= 1'b0;
         neg_seen_ff <= 1'b0;
         failed_ff   <= 1'b0;
         hp_ff       <= '0;
         ln_ff       <= '0;
      end else if (advance) begin
         pos_seen_ff <= pos_seen_in;
         neg_seen_ff <= neg_seen_in;
         failed_ff   <= failed_in;
         hp_ff       <= hp_in;
         ln_ff       <= ln_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sep_ff  <= !fail_now;
         rsp_done_ff <= s1_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_still_separable = rsp_sep_ff;
   assign rsp_set_done        = rsp_done_ff;

   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !(advance && s1_last_ff)) |=> failed_ff)
      else $error("failure cleared within a set");

   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (!failed_ff && !pos_seen_ff && !neg_seen_ff))
      else $error("set state not restarted after last item");

   a_order_held: assert property (@(posedge clock) disable iff (reset)
      (!failed_ff && pos_seen_ff && neg_seen_ff) |-> (hp_ff < ln_ff))
      else $error("ordering clash without failure");

   a_fail_result: assert property (@(posedge clock) disable iff (reset)
      (advance && failed_ff) |=> (rsp_valid_ff && !rsp_sep_ff))
      else $error("separable result reported after failure");

endmodule

`default_nettype wire

>>> test/separability_checker.sv
module separability_checker
   import orlcc_pkg::*;
#(
   parameter int MAX_RULES = 4,
   parameter int FEATURES  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [MASK_W-1:0]     req_point_bits,
   input  wire logic                  req_point_class,
   input  wire logic                  req_last_point,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  rsp_still_separable,
   input  wire logic                  rsp_set_done,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MASK_W-1:0] FEAT_MASK =
      (FEATURES >= MASK_W) ? '1 : MASK_W'((1 << FEATURES) - 1);

   typedef struct packed {
      logic separable;
      logic done;
   } verdict_t;

   logic [COUNT_W-1:0]    cfg_count;
   logic [CSR_DATA_W-1:0] cfg_rule [RULE_REGS];
   logic                  cfg_pos_label;

   logic         pos_seen;
   logic         neg_seen;
   logic         set_failed;
   rule_idx_type top_pos;
   rule_idx_type low_neg;

   verdict_t verdicts_due [$];

   function automatic verdict_t judge_point(input logic [MASK_W-1:0] bits_in,
                                            input logic cls, input logic last);
      int n;
      logic hit;
      logic positive;
      logic [MASK_W-1:0] bits;
      logic [MASK_W-1:0] ones;
      logic [MASK_W-1:0] zeros;
      rule_idx_type fired;
      verdict_t v;
      bits = bits_in & FEAT_MASK;
      n = cfg_count;
      if (n > MAX_RULES) n = MAX_RULES;
      if (n > RULE_REGS) n = RULE_REGS;
      hit = 1'b0;
      fired = '0;
      for (int i = 0; i < n; i++) begin
         ones  = cfg_rule[i][CSR_DATA_W-1:MASK_W] & FEAT_MASK;
         zeros = cfg_rule[i][MASK_W-1:0] & FEAT_MASK;
         if (!hit && (bits & ones) == ones && (bits & zeros) == '0) begin
            hit = 1'b1;
            fired = rule_idx_type'(i);
         end
      end
      positive = (cls == cfg_pos_label);
      if (!set_failed) begin
         if (hit) begin
            if (positive) begin
               if (!pos_seen || fired > top_pos) begin
                  pos_seen = 1'b1;
                  top_pos = fired;
                  if (neg_seen && top_pos >= low_neg) set_failed = 1'b1;
               end
            end else if (!neg_seen || fired < low_neg) begin
               neg_seen = 1'b1;
               low_neg = fired;
               if (pos_seen && top_pos >= low_neg) set_failed = 1'b1;
            end
         end else if (positive) begin
            set_failed = 1'b1;
         end
      end
      v.separable = !set_failed;
      v.done = last;
      if (last) begin
         pos_seen = 1'b0;
         neg_seen = 1'b0;
         set_failed = 1'b0;
         top_pos = '0;
         low_neg = '0;
      end
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_t want;
      if (reset) begin
         cfg_count = '0;
         for (int i = 0; i < RULE_REGS; i++) cfg_rule[i] = '0;
         cfg_pos_label = 1'b0;
         pos_seen = 1'b0;
         neg_seen = 1'b0;
         set_failed = 1'b0;
         top_pos = '0;
         low_neg = '0;
         verdicts_due.delete();
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RULE_COUNT:     cfg_count = csr_wdata[COUNT_W-1:0];
               CSR_RULE_ZERO:      cfg_rule[0] = csr_wdata;
               CSR_RULE_ONE:       cfg_rule[1] = csr_wdata;
               CSR_RULE_TWO:       cfg_rule[2] = csr_wdata;
               CSR_RULE_THREE:     cfg_rule[3] = csr_wdata;
               CSR_POSITIVE_LABEL: cfg_pos_label = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected item separable=%0b done=%0b",
                           $realtime, rsp_still_separable, rsp_set_done);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_still_separable !== want.separable || rsp_set_done !== want.done) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: separable exp %0b got %0b, done exp %0b got %0b",
                              $realtime, want.separable, rsp_still_separable,
                              want.done, rsp_set_done);
               end
            end
         end
         if (req_valid && req_ready)
            verdicts_due.push_back(judge_point(req_point_bits, req_point_class,
                                               req_last_point));
         outstanding <= verdicts_due.size();
      end
   end

endmodule

>>> test/tb_ordered_rule_list_consistency_check.sv
module tb_ordered_rule_list_consistency_check;
   timeunit 1ns;
   timeprecision 1ps;
   import orlcc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int ROUNDS      = 10;
   localparam int ROUND_ITEMS = 175;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MASK_W-1:0]     req_point_bits;
   logic                  req_point_class;
   logic                  req_last_point;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_still_separable;
   logic                  rsp_set_done;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   fail_count;
   int   outstanding;
   int   idle_cycles = 0;
   int   ready_hold = 0;
   logic steady = 1'b0;
   logic [CSR_DATA_W-1:0] cur_rules [RULE_REGS];

   always #2 clock = ~clock;

   ordered_rule_list_consistency_check u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_bits      (req_point_bits),
      .req_point_class     (req_point_class),
      .req_last_point      (req_last_point),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_still_separable (rsp_still_separable),
      .rsp_set_done        (rsp_set_done),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   separability_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_bits      (req_point_bits),
      .req_point_class     (req_point_class),
      .req_last_point      (req_last_point),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_still_separable (rsp_still_separable),
      .rsp_set_done        (rsp_set_done),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // result-side backpressure: long ready runs, short stalls, rare long stalls
   always @(posedge clock) begin : stall_gen
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady) begin
         rsp_ready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (roll < 55) begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end else if (roll < 93) begin
         rsp_ready <= 1'b0;
         ready_hold <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold <= $urandom_range(5, 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_point(input logic [MASK_W-1:0] bits, input logic cls,
                             input logic last);
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 25);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_bits <= bits;
      req_point_class <= cls;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_rules(input logic [COUNT_W-1:0] count,
                             input logic [CSR_DATA_W-1:0] r0, r1, r2, r3,
                             input logic label);
      cur_rules[0] = r0;
      cur_rules[1] = r1;
      cur_rules[2] = r2;
      cur_rules[3] = r3;
      write_reg(CSR_RULE_COUNT, CSR_DATA_W'(count));
      write_reg(CSR_RULE_ZERO, r0);
      write_reg(CSR_RULE_ONE, r1);
      write_reg(CSR_RULE_TWO, r2);
      write_reg(CSR_RULE_THREE, r3);
      write_reg(CSR_POSITIVE_LABEL, CSR_DATA_W'(label));
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_rule();
      logic [MASK_W-1:0] one_m;
      logic [MASK_W-1:0] zero_m;
      one_m = MASK_W'($urandom & $urandom & $urandom);
      zero_m = MASK_W'($urandom & $urandom & $urandom);
      if ($urandom_range(0, 7) != 0) zero_m &= ~one_m;
      return {one_m, zero_m};
   endfunction

   // mostly points built to satisfy one rule, so the ordering logic gets exercised
   function automatic logic [MASK_W-1:0] random_point();
      int unsigned r;
      logic [CSR_DATA_W-1:0] rule;
      if ($urandom_range(0, 99) >= 75) return MASK_W'($urandom);
      r = $urandom_range(0, RULE_REGS - 1);
      rule = cur_rules[r];
      return (MASK_W'($urandom) | rule[CSR_DATA_W-1:MASK_W]) & ~rule[MASK_W-1:0];
   endfunction

   initial begin
      int unsigned set_left;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_point_bits <= '0;
      req_point_class <= 1'b0;
      req_last_point <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_RULE_COUNT;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // rule 2 contradictory, rule 3 empty
      load_rules(3'd4, {16'h8000, 16'h0001}, {16'h0001, 16'h0000},
                 {16'h0010, 16'h0010}, 32'h0, 1'b1);
      send_point(16'h8000, 1'b1, 1'b0);
      send_point(16'h0001, 1'b0, 1'b0);
      send_point(16'hFFFF, 1'b1, 1'b1);
      send_point(16'h0000, 1'b0, 1'b0);
      send_point(16'h0010, 1'b1, 1'b0);
      send_point(16'h8000, 1'b1, 1'b1);
      wait_idle();
      // uncovered negative, covered positive, then uncovered positive
      load_rules(3'd2, {16'h8000, 16'h0001}, {16'h0001, 16'h0000},
                 {16'h0010, 16'h0010}, 32'h0, 1'b1);
      send_point(16'h0000, 1'b0, 1'b0);
      send_point(16'h8000, 1'b1, 1'b0);
      send_point(16'h0000, 1'b1, 1'b1);
      wait_idle();
      // count saturates, class 0 positive, count drops to zero inside a set
      load_rules(3'd7, {16'h8000, 16'h0001}, {16'h0001, 16'h0000},
                 {16'h0010, 16'h0010}, 32'h0, 1'b0);
      send_point(16'h0000, 1'b1, 1'b0);
      send_point(16'hFFFE, 1'b0, 1'b0);
      send_point(16'h0001, 1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_RULE_COUNT, '0);
      csr_wr_en <= 1'b0;
      send_point(16'h1234, 1'b0, 1'b1);
      wait_idle();
      load_rules(3'd0, '1, '1, '1, '1, 1'b1);
      send_point(16'hFFFF, 1'b0, 1'b1);
      send_point(16'h0000, 1'b1, 1'b0);
      send_point(16'h5555, 1'b1, 1'b1);
      wait_idle();

      for (int stage = 0; stage < ROUNDS; stage++) begin
         steady <= (stage % 4 == 2);
         if (stage == 0)
            load_rules(3'd4, '1, '1, '1, '1, 1'($urandom));
         else if (stage == 1)
            load_rules(3'd7, '0, '0, '0, '0, 1'($urandom));
         else
            load_rules(($urandom_range(0, 99) < 70) ? COUNT_W'($urandom_range(3, 4))
                                                    : COUNT_W'($urandom_range(0, 7)),
                       random_rule(), random_rule(), random_rule(), random_rule(),
                       1'($urandom));
         set_left = 0;
         for (int k = 0; k < ROUND_ITEMS; k++) begin
            if (set_left == 0)
               set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            if (k == ROUND_ITEMS / 2 && stage > 1) begin
               wait_idle();
               write_reg(CSR_RULE_COUNT, CSR_DATA_W'($urandom_range(0, 7)));
               csr_wr_en <= 1'b0;
            end
            send_point(random_point(), 1'($urandom), set_left == 1);
            set_left--;
         end
         wait_idle();
      end

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
